// ===== rtl/core/rbss_pkg.sv =====
// ----------------------------------------------------------------------------
// rbss_pkg
// Shared types, constants and helpers of the ring buffer segment splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbss_pkg;

  localparam int unsigned MaxCursors = 4;
  localparam int unsigned IdxW       = 16;
  localparam int unsigned CntW       = 3;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_NEXT    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]      command;
    logic [IdxW-1:0] run_length;
    logic [CntW-1:0] cursor_count;
    logic [IdxW-1:0] start_pos_0;
    logic [IdxW-1:0] start_pos_1;
    logic [IdxW-1:0] start_pos_2;
    logic [IdxW-1:0] start_pos_3;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] segment_length;
    logic [IdxW-1:0] remaining_length;
    logic [IdxW-1:0] seg_pos_0;
    logic [IdxW-1:0] seg_pos_1;
    logic [IdxW-1:0] seg_pos_2;
    logic [IdxW-1:0] seg_pos_3;
    logic [1:0]      status;
  } out_item_t;

  typedef logic [MaxCursors-1:0][IdxW-1:0] cursor_vec_t;

  // margin holds size - pos for each cursor, kept alongside the position
  typedef struct packed {
    logic [IdxW-1:0] size;
    cursor_vec_t     pos;
    cursor_vec_t     margin;
    logic [IdxW-1:0] rem;
    logic [IdxW-1:0] seg;
    logic [CntW-1:0] active;
  } state_t;

  // Segment is the smallest of the remaining length and the active margins.
  function automatic logic [IdxW-1:0] seg_min(input logic [IdxW-1:0] rem,
                                              input cursor_vec_t     margin,
                                              input logic [CntW-1:0] active);
    logic [IdxW-1:0] m;
    m = rem;
    for (int i = 0; i < MaxCursors; i++) begin
      if ((CntW'(i) < active) && (margin[i] < m)) begin
        m = margin[i];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rbss_step.sv =====
// ----------------------------------------------------------------------------
// rbss_step
// Command decode and next-state / result computation for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module rbss_step import rbss_pkg::*; (
  input  in_item_t  item_i,
  input  state_t    cur_i,
  output state_t    nxt_o,
  output logic      upd_o,
  output out_item_t res_o
);

  cursor_vec_t     sp;
  state_t          calc;
  logic            ok;
  logic [1:0]      stat;
  state_t          nxt;
  cursor_vec_t     out_pos;

  assign sp[0] = item_i.start_pos_0;
  assign sp[1] = item_i.start_pos_1;
  assign sp[2] = item_i.start_pos_2;
  assign sp[3] = item_i.start_pos_3;

  always_comb begin
    calc = cur_i;
    ok   = 1'b0;
    stat = STAT_REJECT;
    unique case (item_i.command)
      CMD_START: begin
        ok = (item_i.run_length != '0) && (item_i.cursor_count != '0) &&
             (item_i.cursor_count <= CntW'(MaxCursors));
        for (int i = 0; i < MaxCursors; i++) begin
          if ((CntW'(i) < item_i.cursor_count) && (sp[i] >= cur_i.size)) begin
            ok = 1'b0;
          end
        end
        calc.active = item_i.cursor_count;
        for (int i = 0; i < MaxCursors; i++) begin
          if (CntW'(i) < item_i.cursor_count) begin
            calc.pos[i]    = sp[i];
            calc.margin[i] = cur_i.size - sp[i];
          end
        end
        calc.rem = item_i.run_length;
        calc.seg = seg_min(item_i.run_length, calc.margin, item_i.cursor_count);
        stat     = STAT_OK;
      end
      CMD_RESTART: begin
        ok       = item_i.run_length != '0;
        calc.rem = item_i.run_length;
        calc.seg = seg_min(item_i.run_length, cur_i.margin, cur_i.active);
        stat     = STAT_OK;
      end
      CMD_NEXT: begin
        ok       = cur_i.rem != '0;
        calc.rem = cur_i.rem - cur_i.seg;
        for (int i = 0; i < MaxCursors; i++) begin
          if (CntW'(i) < cur_i.active) begin
            // segment never passes the end, so reaching it exactly means wrap
            if (cur_i.margin[i] == cur_i.seg) begin
              calc.pos[i]    = '0;
              calc.margin[i] = cur_i.size;
            end else begin
              calc.pos[i]    = cur_i.pos[i] + cur_i.seg;
              calc.margin[i] = cur_i.margin[i] - cur_i.seg;
            end
          end
        end
        calc.seg = seg_min(calc.rem, calc.margin, cur_i.active);
        stat     = (calc.rem == '0) ? STAT_DONE : STAT_OK;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      stat = STAT_REJECT;
    end
  end

  assign nxt   = ok ? calc : cur_i;
  assign nxt_o = nxt;
  assign upd_o = ok;

  always_comb begin
    for (int i = 0; i < MaxCursors; i++) begin
      out_pos[i] = (CntW'(i) < nxt.active) ? nxt.pos[i] : '0;
    end
  end

  assign res_o.segment_length   = nxt.seg;
  assign res_o.remaining_length = nxt.rem;
  assign res_o.seg_pos_0        = out_pos[0];
  assign res_o.seg_pos_1        = out_pos[1];
  assign res_o.seg_pos_2        = out_pos[2];
  assign res_o.seg_pos_3        = out_pos[3];
  assign res_o.status           = stat;

endmodule

`default_nettype wire

// ===== rtl/core/rbss_state.sv =====
// ----------------------------------------------------------------------------
// rbss_state
// Buffer size register, cursor positions, margins and run bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module rbss_state import rbss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_data_i,
  input  logic            upd_i,
  input  state_t          nxt_i,
  output state_t          st_o
);

  state_t          st_q;
  state_t          st_d;
  logic [IdxW-1:0] size_w;

  assign size_w = (cfg_data_i == '0) ? IdxW'(1) : cfg_data_i;

  always_comb begin
    st_d = st_q;
    if (cfg_we_i) begin
      // size write: all cursors back to zero, run cleared, cursor count kept
      st_d.size = size_w;
      st_d.rem  = '0;
      st_d.seg  = '0;
      for (int i = 0; i < MaxCursors; i++) begin
        st_d.pos[i]    = '0;
        st_d.margin[i] = size_w;
      end
    end else if (upd_i) begin
      st_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.size   <= IdxW'(1);
      st_q.rem    <= '0;
      st_q.seg    <= '0;
      st_q.active <= CntW'(1);
      for (int i = 0; i < MaxCursors; i++) begin
        st_q.pos[i]    <= '0;
        st_q.margin[i] <= IdxW'(1);
      end
    end else begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

  a_seg_le_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.seg <= st_q.rem)
    else $error("segment exceeds remaining length");

  a_margin_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.margin[0] != '0) && (st_q.size != '0))
    else $error("cursor 0 margin or buffer size is zero");

  a_active_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.active != '0) && (st_q.active <= CntW'(MaxCursors)))
    else $error("active cursor count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ring_buffer_segment_splitter_core.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_segment_splitter_core
// Cuts a run into segments that never cross the end of a circular buffer.
// ----------------------------------------------------------------------------
// Each command produces one result. A command is registered on input, its
// segment is worked out (one minimum over the run and the active margins plus
// adds and wrap compares) and the result is registered on output; one command
// per cycle is sustained while the output is not stalled, the rate being set
// by the update of the cursor state between the two registers. A full output
// register holding a stalled result does not block a new command from
// entering an empty input register. Write buffer_size only while idle; the
// write clears all cursors and the run.
`default_nettype none

module ring_buffer_segment_splitter_core import rbss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_take;
  logic      in_accept;
  logic      fire;
  state_t    st;
  state_t    nxt;
  logic      upd;
  out_item_t res;

  assign cfg_ready_o = 1'b1;

  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_take;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fire       = in_valid_q && out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !fire);
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  rbss_step u_step (
    .item_i (in_q),
    .cur_i  (st),
    .nxt_o  (nxt),
    .upd_o  (upd),
    .res_o  (res)
  );

  rbss_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .upd_i      (fire && upd),
    .nxt_i      (nxt),
    .st_o       (st)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == STAT_DONE)) |->
      ((out_q.segment_length == '0) && (out_q.remaining_length == '0)))
    else $error("finished result with nonzero length");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && in_valid_q))
    else $error("input stalled while pipeline not full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// ===== test/rbss_segment_checker.sv =====
// ----------------------------------------------------------------------------
// rbss_segment_checker
// Watches the config, command and segment channels of the splitter, tracks
// the buffer size, cursors and run length itself, and compares every
// segment transfer field by field against the oldest predicted segment.
// ----------------------------------------------------------------------------
module rbss_segment_checker import rbss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [IdxW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_item_t        in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_item_t       out_data_i,
  output int unsigned     pending_o,
  output int unsigned     fail_count_o
);

  logic [IdxW-1:0] buf_size;
  logic [IdxW-1:0] cursor_pos [MaxCursors];
  logic [IdxW-1:0] left_len;
  logic [IdxW-1:0] seg_len;
  logic [CntW-1:0] n_active;
  out_item_t       segment_q [$];
  int unsigned     mismatches = 0;

  // Shortest of the remaining run and each active cursor's room to the end.
  function automatic logic [IdxW-1:0] shortest_span();
    logic [IdxW-1:0] span;
    span = left_len;
    for (int i = 0; i < MaxCursors; i++) begin
      if (i < n_active && (buf_size - cursor_pos[i]) < span) begin
        span = buf_size - cursor_pos[i];
      end
    end
    return span;
  endfunction

  task automatic load_size(input logic [IdxW-1:0] value);
    buf_size = (value == '0) ? IdxW'(1) : value;
    for (int i = 0; i < MaxCursors; i++) begin
      cursor_pos[i] = '0;
    end
    left_len = '0;
    seg_len  = '0;
  endtask

  task automatic step_command(input in_item_t cmd, output out_item_t seg);
    logic [IdxW-1:0] start_pos [MaxCursors];
    logic [IdxW:0]   moved;
    logic            ok;
    status_e         stat;
    start_pos[0] = cmd.start_pos_0;
    start_pos[1] = cmd.start_pos_1;
    start_pos[2] = cmd.start_pos_2;
    start_pos[3] = cmd.start_pos_3;
    stat = STAT_REJECT;
    case (cmd.command)
      CMD_START: begin
        ok = (cmd.run_length != '0) && (cmd.cursor_count >= 1) &&
             (cmd.cursor_count <= MaxCursors);
        for (int i = 0; i < MaxCursors; i++) begin
          if (i < cmd.cursor_count && start_pos[i] >= buf_size) ok = 1'b0;
        end
        if (ok) begin
          n_active = cmd.cursor_count;
          for (int i = 0; i < MaxCursors; i++) begin
            if (i < n_active) cursor_pos[i] = start_pos[i];
          end
          left_len = cmd.run_length;
          seg_len  = shortest_span();
          stat     = STAT_OK;
        end
      end
      CMD_RESTART: begin
        if (cmd.run_length != '0) begin
          left_len = cmd.run_length;
          seg_len  = shortest_span();
          stat     = STAT_OK;
        end
      end
      CMD_NEXT: begin
        if (left_len != '0) begin
          left_len = left_len - seg_len;
          for (int i = 0; i < MaxCursors; i++) begin
            if (i < n_active) begin
              moved = {1'b0, cursor_pos[i]} + {1'b0, seg_len};
              cursor_pos[i] = (moved >= {1'b0, buf_size}) ? '0 : moved[IdxW-1:0];
            end
          end
          seg_len = shortest_span();
          stat    = (left_len == '0) ? STAT_DONE : STAT_OK;
        end
      end
      default: stat = STAT_REJECT;
    endcase
    seg.segment_length   = seg_len;
    seg.remaining_length = left_len;
    seg.seg_pos_0        = (n_active > 0) ? cursor_pos[0] : '0;
    seg.seg_pos_1        = (n_active > 1) ? cursor_pos[1] : '0;
    seg.seg_pos_2        = (n_active > 2) ? cursor_pos[2] : '0;
    seg.seg_pos_3        = (n_active > 3) ? cursor_pos[3] : '0;
    seg.status           = stat;
  endtask

  task automatic compare_field(input string name, input logic [IdxW-1:0] want,
                               input logic [IdxW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      load_size(IdxW'(1));
      n_active = CntW'(1);
      segment_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (segment_q.size() == 0) begin
          $display("%0t: unexpected segment: expected none, actual %h", $time, out_data_i);
          mismatches++;
        end else begin
          want = segment_q.pop_front();
          compare_field("segment_length", want.segment_length, out_data_i.segment_length);
          compare_field("remaining_length", want.remaining_length,
                        out_data_i.remaining_length);
          compare_field("seg_pos_0", want.seg_pos_0, out_data_i.seg_pos_0);
          compare_field("seg_pos_1", want.seg_pos_1, out_data_i.seg_pos_1);
          compare_field("seg_pos_2", want.seg_pos_2, out_data_i.seg_pos_2);
          compare_field("seg_pos_3", want.seg_pos_3, out_data_i.seg_pos_3);
          compare_field("status", IdxW'(want.status), IdxW'(out_data_i.status));
        end
      end
      if (cfg_valid_i && cfg_ready_i) load_size(cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        step_command(in_data_i, want);
        segment_q.push_back(want);
      end
    end
    pending_o    <= segment_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== test/ring_buffer_segment_splitter_core_tb.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_segment_splitter_core_tb
// Drives directed corner commands and then random start/next/restart runs
// over many buffer sizes, with random idle and stall bursts; the checker
// beside the block predicts and compares every segment transfer.
// ----------------------------------------------------------------------------
module ring_buffer_segment_splitter_core_tb;
  import rbss_pkg::*;

  localparam int unsigned NumItems   = 550;
  localparam int unsigned CalmItems  = 100;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            idle_on   = 1'b0;
  int unsigned     pending;
  int unsigned     fail_count;
  int unsigned     sent      = 0;
  int unsigned     cycle_cnt = 0;
  int unsigned     stall_left = 0;

  ring_buffer_segment_splitter_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  rbss_segment_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL ring_buffer_segment_splitter_core");
      $finish;
    end
  end

  // Random receiver stall bursts, started only while idle_on is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t cmd_item(input logic [1:0] op, input int len, input int cnt,
                                        input int p0, input int p1, input int p2,
                                        input int p3);
    in_item_t it;
    it.command      = op;
    it.run_length   = len[IdxW-1:0];
    it.cursor_count = cnt[CntW-1:0];
    it.start_pos_0  = p0[IdxW-1:0];
    it.start_pos_1  = p1[IdxW-1:0];
    it.start_pos_2  = p2[IdxW-1:0];
    it.start_pos_3  = p3[IdxW-1:0];
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return cmd_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535), $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  function automatic int pick_length(input int eff);
    int hi;
    hi = (3 * eff > 65535) ? 65535 : 3 * eff;
    if ($urandom_range(0, 1) == 0) return $urandom_range(1, eff);
    return $urandom_range(1, hi);
  endfunction

  // Mostly well-formed starts; one in eight is broken on purpose.
  function automatic in_item_t start_item(input int eff);
    int pos [MaxCursors];
    int cnt;
    int len;
    int k;
    cnt = $urandom_range(1, MaxCursors);
    len = pick_length(eff);
    for (int i = 0; i < MaxCursors; i++) begin
      pos[i] = (i < cnt) ? $urandom_range(0, eff - 1) : $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(0, 2);
      if (k == 0) len = 0;
      else if (k == 1) cnt = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 7);
      else pos[$urandom_range(0, cnt - 1)] = $urandom_range(eff, 65535);
    end
    return cmd_item(CMD_START, len, cnt, pos[0], pos[1], pos[2], pos[3]);
  endfunction

  task automatic send_cmd(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Size writes happen only once every segment has come back.
  task automatic write_size(input logic [IdxW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int size_w;
    int eff;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Size is 1 out of reset.
    send_cmd(cmd_item(CMD_NEXT, 0, 1, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_RESTART, 0, 1, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 0, 1, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 5, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 5, 5, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 5, 7, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 5, 1, 1, 0, 0, 0));
    send_cmd(cmd_item(CmdUnused, 65535, 7, 65535, 65535, 65535, 65535));
    send_cmd(cmd_item(CMD_START, 2, 4, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    // zero size is taken as one
    write_size('0);
    send_cmd(cmd_item(CMD_RESTART, 1, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    write_size(16'hFFFF);
    send_cmd(cmd_item(CMD_START, 65535, 4, 65534, 0, 32767, 1));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_RESTART, 65535, 0, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 100, 3, 0, 0, 65535, 0));
    send_cmd(cmd_item(CMD_START, 100, 6, 0, 0, 0, 0));
    send_cmd(cmd_item(CMD_START, 40000, 2, 30000, 50000, 0, 65535));
    send_cmd(cmd_item(CMD_NEXT, 0, 0, 0, 0, 0, 0));

    while (sent < NumItems) begin
      idle_on <= (sent + CalmItems < NumItems) && ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 9);
      if (k == 0) size_w = 65535;
      else if (k == 1) size_w = $urandom_range(0, 65535);
      else if (k == 2) size_w = 1;
      else size_w = $urandom_range(2, 40);
      eff = (size_w == 0) ? 1 : size_w;
      write_size(size_w[IdxW-1:0]);
      repeat ($urandom_range(2, 6)) begin
        send_cmd(start_item(eff));
        repeat ($urandom_range(1, 10)) begin
          k = $urandom_range(0, 19);
          if (k == 0) send_cmd(noise_item());
          else if (k == 1) send_cmd(cmd_item(CMD_RESTART,
                                             ($urandom_range(0, 5) == 0) ? 0 : pick_length(eff),
                                             $urandom_range(0, 7), $urandom_range(0, 65535),
                                             0, 0, $urandom_range(0, 65535)));
          else send_cmd(cmd_item(CMD_NEXT, $urandom_range(0, 65535), $urandom_range(0, 7),
                                 0, $urandom_range(0, 65535), 0, 0));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS ring_buffer_segment_splitter_core");
    end else begin
      $display("FAIL ring_buffer_segment_splitter_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rbss_pkg.sv
rtl/core/rbss_step.sv
rtl/core/rbss_state.sv
rtl/core/ring_buffer_segment_splitter_core.sv
test/rbss_segment_checker.sv
test/ring_buffer_segment_splitter_core_tb.sv
